@@ rtl/llim_pkg.sv @@
package llim_pkg;

    localparam int MAX_FRAMES  = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int ADDR_BITS   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_BITS    = $clog2(MAX_FRAMES + 1);
    localparam int DIV_BITS    = $clog2(FRAC_BITS);
    localparam int PROD_BITS   = 2 * SAMPLE_BITS + 1;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int CHAN_BITS   = 2;

    localparam logic [GAIN_BITS-1:0] ONE_GAIN = GAIN_BITS'(1) << FRAC_BITS;
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CEILING  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE  = 2'd3;

    localparam logic [CHAN_BITS-1:0]     RST_CHANNELS = 2'd2;
    localparam logic [CFG_DATA_BITS-1:0] RST_CEILING  = 24'd8388608;
    localparam logic [CFG_DATA_BITS-1:0] RST_ATTACK   = 24'd34953;
    localparam logic [CFG_DATA_BITS-1:0] RST_RELEASE  = 24'd3495;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_FWD_INIT,
        ST_FWD_PRIME,
        ST_FWD_RD,
        ST_FWD_WR,
        ST_BWD_RD,
        ST_BWD_WR,
        ST_OUT_RD,
        ST_OUT_MUL,
        ST_OUT_WAIT
    } state_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic    in_ready;
        logic    div_step;
        logic    store_gain;
        logic    prev_load;
        logic    pass_wr;
        logic    backward;
        logic    mul_load;
        logic    out_load;
        logic    count_clr;
        idx_op_t idx_op;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic need_div;
        logic div_last;
        logic block_end;
        logic one_frame;
        logic idx_last;
        logic idx_zero;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/llim_in_if.sv @@
interface llim_in_if
    import llim_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic                          last_frame;

    modport source (output valid, sample_a, sample_b, last_frame, input ready);
    modport sink   (input valid, sample_a, sample_b, last_frame, output ready);
endinterface

@@ rtl/llim_out_if.sv @@
interface llim_out_if
    import llim_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_a;
    logic signed [SAMPLE_BITS-1:0] out_b;
    logic [GAIN_BITS-1:0]          applied_gain;
    logic                          last_out;

    modport source (output valid, out_a, out_b, applied_gain, last_out, input ready);
    modport sink   (input valid, out_a, out_b, applied_gain, last_out, output ready);
endinterface

@@ rtl/llim_cfg_if.sv @@
interface llim_cfg_if
    import llim_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lookahead_peak_limiter.sv @@
// Look-ahead peak limiter with linked channels. Frames of one or two channels are
// collected into a block of up to MAX_FRAMES frames; for each frame the limiter
// computes the gain that brings the louder channel down to the ceiling. The block
// is released when a frame marked last_frame arrives or the store is full. The
// gains are then smoothed by a forward pass (rise limited by release_step) and a
// backward pass (rise limited by attack_step), and every frame is sent out scaled
// by its gain, rounded to nearest, with the gain and an end-of-block mark. A frame
// that must be limited takes longer to load than one below the ceiling, because
// the gain division runs one quotient bit per cycle. Once a block's last frame is
// stored, the forward pass is primed, then the gains of the later frames (forward)
// and of the earlier frames (backward) are each read through the registered memory
// port before they are rewritten, and every result is read, scaled and sent, which
// takes longer if the receiver holds off a request. No new frame is taken while a
// block is being sent out. Configuration writes are always accepted and take
// effect at once.
module lookahead_peak_limiter
    import llim_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    llim_cfg_if.sink   cfg,
    llim_in_if.sink    frames,
    llim_out_if.source results
);
    cmd_t cmd;
    sts_t sts;

    // Sample memory: one row per frame, both channels side by side.
    logic                       samp_we;
    logic [ADDR_BITS-1:0]       samp_waddr;
    logic [2*SAMPLE_BITS-1:0]   samp_wdata;
    logic [ADDR_BITS-1:0]       samp_raddr;
    logic [2*SAMPLE_BITS-1:0]   samp_rdata;

    // Gain memory: written once per frame at load and again by each pass.
    logic                       gain_we;
    logic [ADDR_BITS-1:0]       gain_waddr;
    logic [GAIN_BITS-1:0]       gain_wdata;
    logic [ADDR_BITS-1:0]       gain_raddr;
    logic [GAIN_BITS-1:0]       gain_rdata;

    llim_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    llim_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .frames     (frames),
        .results    (results),
        .cmd        (cmd),
        .sts        (sts),
        .samp_we    (samp_we),
        .samp_waddr (samp_waddr),
        .samp_wdata (samp_wdata),
        .samp_raddr (samp_raddr),
        .samp_rdata (samp_rdata),
        .gain_we    (gain_we),
        .gain_waddr (gain_waddr),
        .gain_wdata (gain_wdata),
        .gain_raddr (gain_raddr),
        .gain_rdata (gain_rdata)
    );

    llim_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_samp_ram (
        .clk   (clk),
        .we    (samp_we),
        .waddr (samp_waddr),
        .wdata (samp_wdata),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    llim_ram #(
        .WIDTH (GAIN_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_gain_ram (
        .clk   (clk),
        .we    (gain_we),
        .waddr (gain_waddr),
        .wdata (gain_wdata),
        .raddr (gain_raddr),
        .rdata (gain_rdata)
    );
endmodule

@@ rtl/llim_ram.sv @@
module llim_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/llim_ctrl.sv @@
module llim_ctrl
    import llim_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!sts.need_div || sts.div_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:     state_next = sts.block_end ? ST_FWD_INIT : ST_IDLE;
            ST_FWD_INIT:  state_next = ST_FWD_PRIME;
            ST_FWD_PRIME: state_next = sts.one_frame ? ST_OUT_RD : ST_FWD_RD;
            ST_FWD_RD:    state_next = ST_FWD_WR;
            ST_FWD_WR:    state_next = sts.idx_last ? ST_BWD_RD : ST_FWD_RD;
            ST_BWD_RD:    state_next = ST_BWD_WR;
            ST_BWD_WR:    state_next = sts.idx_zero ? ST_OUT_RD : ST_BWD_RD;
            ST_OUT_RD:    state_next = ST_OUT_MUL;
            ST_OUT_MUL:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.idx_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.idx_op = IDX_HOLD;
        unique case (state_reg)
            ST_IDLE:      cmd.in_ready = 1'b1;
            ST_DIVIDE:    cmd.div_step = 1'b1;
            ST_STORE:
            begin
                cmd.store_gain = 1'b1;
                if (sts.block_end)
                begin
                    cmd.idx_op = IDX_CLR;
                end
            end
            ST_FWD_INIT:  cmd.idx_op = IDX_INC;
            ST_FWD_PRIME:
            begin
                cmd.prev_load = 1'b1;
                if (sts.one_frame)
                begin
                    cmd.idx_op = IDX_CLR;
                end
            end
            ST_FWD_RD:    cmd.idx_op = IDX_HOLD;
            ST_FWD_WR:
            begin
                cmd.pass_wr = 1'b1;
                cmd.idx_op  = sts.idx_last ? IDX_DEC : IDX_INC;
            end
            ST_BWD_RD:    cmd.backward = 1'b1;
            ST_BWD_WR:
            begin
                cmd.pass_wr  = 1'b1;
                cmd.backward = 1'b1;
                cmd.idx_op   = sts.idx_zero ? IDX_CLR : IDX_DEC;
            end
            ST_OUT_RD:    cmd.idx_op = IDX_HOLD;
            ST_OUT_MUL:   cmd.mul_load = 1'b1;
            ST_OUT_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.idx_op    = IDX_CLR;
                        cmd.count_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            default:      cmd.idx_op = IDX_HOLD;
        endcase
    end
endmodule

@@ rtl/llim_dp.sv @@
module llim_dp
    import llim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    llim_cfg_if.sink          cfg,
    llim_in_if.sink           frames,
    llim_out_if.source        results,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              samp_we,
    output logic [ADDR_BITS-1:0] samp_waddr,
    output logic [2*SAMPLE_BITS-1:0] samp_wdata,
    output logic [ADDR_BITS-1:0] samp_raddr,
    input  logic [2*SAMPLE_BITS-1:0] samp_rdata,
    output logic              gain_we,
    output logic [ADDR_BITS-1:0] gain_waddr,
    output logic [GAIN_BITS-1:0] gain_wdata,
    output logic [ADDR_BITS-1:0] gain_raddr,
    input  logic [GAIN_BITS-1:0] gain_rdata
);
    // Configuration registers.
    logic [CHAN_BITS-1:0]     chans_reg;
    logic [CFG_DATA_BITS-1:0] ceil_reg;
    logic [CFG_DATA_BITS-1:0] attack_reg;
    logic [CFG_DATA_BITS-1:0] release_reg;

    logic accept;
    logic two_ch;
    logic [GAIN_BITS-1:0] mag_a;
    logic [GAIN_BITS-1:0] mag_b;
    logic [GAIN_BITS-1:0] peak_in;

    logic [CNT_BITS-1:0]  count_reg;
    logic [ADDR_BITS-1:0] idx_reg;
    logic [ADDR_BITS-1:0] idx_next;
    logic                 last_reg;
    logic                 out_two_reg;
    logic                 need_div_reg;
    logic [GAIN_BITS-1:0] peak_reg;
    logic [GAIN_BITS-1:0] rem_reg;
    logic [GAIN_BITS-1:0] quo_reg;
    logic [DIV_BITS-1:0]  div_cnt_reg;
    logic [GAIN_BITS:0]   rem_sh;
    logic [GAIN_BITS:0]   rem_diff;
    logic                 rem_ge;

    logic [GAIN_BITS-1:0] prev_reg;
    logic [GAIN_BITS:0]   cap;
    logic [GAIN_BITS-1:0] capped;

    logic signed [SAMPLE_BITS:0]    gain_s;
    logic signed [PROD_BITS-1:0]    prod_a_reg;
    logic signed [PROD_BITS-1:0]    prod_b_reg;
    logic [GAIN_BITS-1:0]           gain_hold_reg;
    logic                           last_hold_reg;
    logic [PROD_BITS-1:0]           rnd_a;
    logic [PROD_BITS-1:0]           rnd_b;

    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  out_a_reg;
    logic signed [SAMPLE_BITS-1:0]  out_b_reg;
    logic [GAIN_BITS-1:0]           out_gain_reg;
    logic                           out_last_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg   <= RST_CHANNELS;
            ceil_reg    <= RST_CEILING;
            attack_reg  <= RST_ATTACK;
            release_reg <= RST_RELEASE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CHANNELS: chans_reg   <= cfg.data[CHAN_BITS-1:0];
                CFG_CEILING:  ceil_reg    <= cfg.data;
                CFG_ATTACK:   attack_reg  <= cfg.data;
                CFG_RELEASE:  release_reg <= cfg.data;
                default:      chans_reg   <= chans_reg;
            endcase
        end
    end

    // Frame capture and linked peak.
    assign frames.ready = cmd.in_ready;
    assign accept = frames.valid && cmd.in_ready;
    assign two_ch = chans_reg[1];
    assign mag_a  = frames.sample_a[SAMPLE_BITS-1] ? GAIN_BITS'(-frames.sample_a)
                                                   : GAIN_BITS'(frames.sample_a);
    assign mag_b  = frames.sample_b[SAMPLE_BITS-1] ? GAIN_BITS'(-frames.sample_b)
                                                   : GAIN_BITS'(frames.sample_b);
    assign peak_in = (two_ch && (mag_b > mag_a)) ? mag_b : mag_a;

    assign samp_we    = accept;
    assign samp_waddr = count_reg[ADDR_BITS-1:0];
    assign samp_wdata = {frames.sample_a, two_ch ? frames.sample_b : SAMPLE_BITS'(0)};
    assign samp_raddr = idx_reg;

    // Restoring divider: one quotient bit per cycle.
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, peak_reg};
    assign rem_diff = rem_sh - {1'b0, peak_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            peak_reg <= peak_in;
            rem_reg  <= ceil_reg;
            quo_reg  <= '0;
            last_reg <= frames.last_frame;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_diff[GAIN_BITS-1:0] : rem_sh[GAIN_BITS-1:0];
            quo_reg <= {quo_reg[GAIN_BITS-2:0], rem_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_div_reg <= 1'b0;
            out_two_reg  <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            need_div_reg <= peak_in > ceil_reg;
            out_two_reg  <= two_ch;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_BITS'(1);
        end
    end

    // Frame count and pass index.
    always_comb
    begin
        idx_next = idx_reg;
        case (cmd.idx_op)
            IDX_CLR: idx_next = '0;
            IDX_INC: idx_next = idx_reg + ADDR_BITS'(1);
            IDX_DEC: idx_next = idx_reg - ADDR_BITS'(1);
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.store_gain)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
        end
    end

    // Gain smoothing: cap at the neighbor's gain plus the step.
    assign cap    = {1'b0, prev_reg} + {1'b0, cmd.backward ? attack_reg : release_reg};
    assign capped = (cap < {1'b0, gain_rdata}) ? cap[GAIN_BITS-1:0] : gain_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.prev_load)
        begin
            prev_reg <= gain_rdata;
        end
        else if (cmd.pass_wr)
        begin
            prev_reg <= capped;
        end
    end

    assign gain_we    = cmd.store_gain || cmd.pass_wr;
    assign gain_waddr = cmd.store_gain ? count_reg[ADDR_BITS-1:0] : idx_reg;
    assign gain_wdata = cmd.store_gain ? (need_div_reg ? quo_reg : ONE_GAIN) : capped;
    assign gain_raddr = idx_reg;

    // Scaling.
    assign gain_s = signed'({1'b0, gain_rdata});

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_a_reg    <= signed'(samp_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) * gain_s;
            prod_b_reg    <= signed'(samp_rdata[SAMPLE_BITS-1:0]) * gain_s;
            gain_hold_reg <= gain_rdata;
            last_hold_reg <= sts.idx_last;
        end
    end

    assign rnd_a = prod_a_reg + ROUND_HALF;
    assign rnd_b = prod_b_reg + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_a_reg    <= rnd_a[FRAC_BITS +: SAMPLE_BITS];
            out_b_reg    <= out_two_reg ? rnd_b[FRAC_BITS +: SAMPLE_BITS] : SAMPLE_BITS'(0);
            out_gain_reg <= gain_hold_reg;
            out_last_reg <= last_hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.out_a        = out_a_reg;
    assign results.out_b        = out_b_reg;
    assign results.applied_gain = out_gain_reg;
    assign results.last_out     = out_last_reg;

    assign sts.in_valid  = frames.valid;
    assign sts.need_div  = need_div_reg;
    assign sts.div_last  = div_cnt_reg == DIV_BITS'(FRAC_BITS - 1);
    assign sts.block_end = last_reg || (count_reg == CNT_BITS'(MAX_FRAMES - 1));
    assign sts.one_frame = count_reg == CNT_BITS'(1);
    assign sts.idx_last  = {1'b0, idx_reg} == CNT_BITS'(count_reg - CNT_BITS'(1));
    assign sts.idx_zero  = idx_reg == '0;
    assign sts.out_free  = !out_valid_reg || results.ready;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_FRAMES))
        else $error("frame count beyond store depth");

    a_quotient_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store_gain && need_div_reg) |-> (quo_reg < ONE_GAIN))
        else $error("limiting gain not below unity");

    a_smoothed_gain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_wr |-> (capped <= ONE_GAIN))
        else $error("smoothed gain above unity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !cmd.out_load)
        else $error("pending result overwritten");
endmodule
